[hw/rtl/lhdf_pkg.sv]
// Shared constants, command/status types and helper functions for the distinct filter.
`timescale 1ns / 1ps
package lhdf_pkg;

	localparam int MAX_BUCKETS = 256;
	localparam int MAX_PAGES   = 8;
	localparam int PAGE_SLOTS  = 64;

	localparam int REC_W     = 32;
	localparam int CAP_W     = 7;
	localparam int CAP_RESET = 16;

	localparam int BKW = $clog2(MAX_BUCKETS);
	localparam int PGW = $clog2(MAX_PAGES);
	localparam int SLW = $clog2(PAGE_SLOTS);
	localparam int NPW = $clog2(MAX_PAGES + 1);
	localparam int FW  = $clog2(PAGE_SLOTS + 1);
	localparam int BCW = $clog2(MAX_BUCKETS + 1);

	localparam int STORE_DEPTH = MAX_BUCKETS * MAX_PAGES * PAGE_SLOTS;
	localparam int FILL_DEPTH  = MAX_BUCKETS * MAX_PAGES;
	localparam int MV_DEPTH    = MAX_PAGES * PAGE_SLOTS;
	localparam int SAW  = $clog2(STORE_DEPTH);
	localparam int FAW  = $clog2(FILL_DEPTH);
	localparam int MAW  = $clog2(MV_DEPTH);
	localparam int MCW  = $clog2(MV_DEPTH + 1);
	localparam int TOTW = $clog2(STORE_DEPTH + 1);
	localparam int PRODW = FW + BCW;
	localparam int CMPW  = TOTW + 2;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD_IN,
		OP_PIB_RD,
		OP_PIB_LATCH,
		OP_FILL_RD,
		OP_FILL_LATCH,
		OP_REC_STEP,
		OP_PAGE_END,
		OP_PL_NEW,
		OP_PL_FILL,
		OP_BK_SP,
		OP_EMIT,
		OP_PROD,
		OP_SPLIT_BEGIN,
		OP_SPLIT_MID,
		OP_MV_RD,
		OP_MV_LATCH,
		OP_MV_NEXT,
		OP_SPLIT_END
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic pg_end;
		logic page_done;
		logic hit;
		logic room;
		logic ok;
		logic out_free;
		logic split_need;
		logic gather;
		logic tgt_sp;
		logic mv_done;
	} dp_status_t;

	// Bucket address: low bits under the next power of two, top bit dropped if past the count.
	function automatic logic [BKW-1:0] bucket_of(input logic [REC_W-1:0] rec,
		input logic [BCW-1:0] bc);
		logic [BCW-1:0] mask;
		logic [BCW-1:0] a;
		mask = bc - 1'b1;
		for (int i = 1; i < BCW; i = i * 2) begin
			mask = mask | (mask >> i);
		end
		a = rec[BCW-1:0] & mask;
		if (a >= bc) begin
			a = a & (mask >> 1);
		end
		if (a >= BCW'(MAX_BUCKETS)) begin
			a = '0;
		end
		return a[BKW-1:0];
	endfunction

	function automatic logic [FW-1:0] cap_eff(input logic [CAP_W-1:0] c);
		if (c == '0) begin
			return FW'(1);
		end
		if (int'(c) > PAGE_SLOTS) begin
			return FW'(PAGE_SLOTS);
		end
		return FW'(c);
	endfunction

endpackage

[hw/rtl/lhdf_ram.sv]
// Generic simple dual-port RAM, one write port and one registered read port.
`timescale 1ns / 1ps
module lhdf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hw/rtl/lhdf_dp.sv]
// Datapath: table memories, table registers, scan/place address logic, output register.
`timescale 1ns / 1ps
module lhdf_dp import lhdf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	output dp_status_t       st,
	input  logic [REC_W-1:0] in_rec,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [REC_W-1:0] out_rec,
	output logic             out_full
);

	logic [REC_W-1:0] rec_q;
	logic [BKW-1:0]   bk_q;
	logic [NPW-1:0]   npg_q;
	logic [NPW-1:0]   pg_q;
	logic [FW-1:0]    fill_q;
	logic [FW-1:0]    slot_q;
	logic [FAW-1:0]   clr_q;
	logic [MCW-1:0]   mv_cnt_q;
	logic [MCW-1:0]   mv_idx_q;
	logic [PRODW-1:0] prod_q;
	logic [CAP_W-1:0] cap_q;
	logic [BCW-1:0]   bc_q;
	logic [BKW-1:0]   sp_q;
	logic [BCW-1:0]   rb_q;
	logic [TOTW-1:0]  total_q;
	logic             hit_q;
	logic             ok_q;
	logic             gather_q;
	logic             rdv_s1;
	logic             out_valid_q;
	logic [REC_W-1:0] out_rec_q;
	logic             out_full_q;

	dp_op_t           op;
	logic [FW-1:0]    cap_e;
	logic             scan_more;
	logic             issue;
	logic             room;
	logic             new_ok;
	logic [BKW+PGW-1:0] pi_cur;
	logic [BKW+PGW-1:0] pi_new;
	logic [BCW-1:0]   sp_next;
	logic [CMPW-1:0]  three_prod;
	logic [CMPW-1:0]  quad_total;

	logic             s_we;
	logic [SAW-1:0]   s_waddr;
	logic [REC_W-1:0] s_rd;
	logic             f_we;
	logic [FAW-1:0]   f_waddr;
	logic [FW-1:0]    f_wdata;
	logic [FW-1:0]    f_rd;
	logic             p_we;
	logic [BKW-1:0]   p_waddr;
	logic [NPW-1:0]   p_wdata;
	logic [NPW-1:0]   p_rd;
	logic             m_we;
	logic [REC_W-1:0] m_rd;

	assign op        = cmd.op;
	assign cap_e     = cap_eff(cap_q);
	assign scan_more = (slot_q < fill_q) && !hit_q;
	assign issue     = (op == OP_REC_STEP) && scan_more;
	assign room      = f_rd < cap_e;
	assign new_ok    = npg_q < NPW'(MAX_PAGES);
	assign pi_cur    = {bk_q, pg_q[PGW-1:0]};
	assign pi_new    = {bk_q, npg_q[PGW-1:0]};
	assign sp_next   = BCW'(sp_q) + 1'b1;
	assign three_prod = CMPW'({prod_q, 1'b0}) + CMPW'(prod_q);
	assign quad_total = {total_q, 2'b00};

	// memory write ports
	assign s_we    = ((op == OP_PL_NEW) && new_ok) || ((op == OP_PL_FILL) && room);
	assign s_waddr = (op == OP_PL_NEW) ? {pi_new, SLW'(0)} : {pi_cur, f_rd[SLW-1:0]};
	assign m_we    = rdv_s1 && gather_q;

	always_comb begin
		f_we    = 1'b0;
		f_waddr = pi_cur;
		f_wdata = '0;
		p_we    = 1'b0;
		p_waddr = bk_q;
		p_wdata = '0;
		unique case (op)
			OP_CLEAR: begin
				f_we    = 1'b1;
				f_waddr = clr_q;
				p_we    = 1'b1;
				p_waddr = clr_q[BKW-1:0];
			end
			OP_PAGE_END: begin
				f_we = gather_q;
			end
			OP_PL_NEW: begin
				f_we    = new_ok;
				f_waddr = pi_new;
				f_wdata = FW'(1);
				p_we    = new_ok;
				p_wdata = NPW'(npg_q + 1'b1);
			end
			OP_PL_FILL: begin
				f_we    = room;
				f_wdata = FW'(f_rd + 1'b1);
			end
			OP_SPLIT_MID: begin
				p_we    = 1'b1;
				p_waddr = sp_q;
			end
			default: begin
			end
		endcase
	end

	lhdf_ram #(.WIDTH(REC_W), .DEPTH(STORE_DEPTH)) u_store (
		.clk     (clk),
		.wr_en   (s_we),
		.wr_addr (s_waddr),
		.wr_data (rec_q),
		.rd_en   (issue),
		.rd_addr ({pi_cur, slot_q[SLW-1:0]}),
		.rd_data (s_rd)
	);

	lhdf_ram #(.WIDTH(FW), .DEPTH(FILL_DEPTH)) u_fill (
		.clk     (clk),
		.wr_en   (f_we),
		.wr_addr (f_waddr),
		.wr_data (f_wdata),
		.rd_en   (op == OP_FILL_RD),
		.rd_addr (pi_cur),
		.rd_data (f_rd)
	);

	lhdf_ram #(.WIDTH(NPW), .DEPTH(MAX_BUCKETS)) u_pib (
		.clk     (clk),
		.wr_en   (p_we),
		.wr_addr (p_waddr),
		.wr_data (p_wdata),
		.rd_en   (op == OP_PIB_RD),
		.rd_addr (bk_q),
		.rd_data (p_rd)
	);

	lhdf_ram #(.WIDTH(REC_W), .DEPTH(MV_DEPTH)) u_moving (
		.clk     (clk),
		.wr_en   (m_we),
		.wr_addr (mv_cnt_q[MAW-1:0]),
		.wr_data (s_rd),
		.rd_en   (op == OP_MV_RD),
		.rd_addr (mv_idx_q[MAW-1:0]),
		.rd_data (m_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			npg_q       <= '0;
			pg_q        <= '0;
			fill_q      <= '0;
			slot_q      <= '0;
			clr_q       <= '0;
			mv_cnt_q    <= '0;
			mv_idx_q    <= '0;
			cap_q       <= CAP_W'(CAP_RESET);
			bc_q        <= BCW'(2);
			sp_q        <= '0;
			rb_q        <= BCW'(2);
			total_q     <= '0;
			hit_q       <= 1'b0;
			ok_q        <= 1'b0;
			gather_q    <= 1'b0;
			rdv_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rdv_s1      <= issue;
			out_valid_q <= (op == OP_EMIT) || (out_valid_q && !out_ready);
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (rdv_s1 && !gather_q && (s_rd == rec_q)) begin
				hit_q <= 1'b1;
			end
			if (m_we) begin
				mv_cnt_q <= mv_cnt_q + 1'b1;
			end
			unique case (op)
				OP_CLEAR: clr_q <= clr_q + 1'b1;
				OP_LOAD_IN: begin
					hit_q    <= 1'b0;
					gather_q <= 1'b0;
				end
				OP_PIB_LATCH: begin
					npg_q <= (p_rd > NPW'(MAX_PAGES)) ? NPW'(MAX_PAGES) : p_rd;
					pg_q  <= '0;
				end
				OP_FILL_LATCH: begin
					fill_q <= (f_rd > FW'(PAGE_SLOTS)) ? FW'(PAGE_SLOTS) : f_rd;
					slot_q <= '0;
				end
				OP_REC_STEP: begin
					if (scan_more) begin
						slot_q <= slot_q + 1'b1;
					end
				end
				OP_PAGE_END: pg_q <= pg_q + 1'b1;
				OP_PL_NEW: ok_q <= new_ok;
				OP_PL_FILL: begin
					if (room) begin
						ok_q <= 1'b1;
					end else begin
						pg_q <= pg_q + 1'b1;
					end
				end
				OP_EMIT: total_q <= total_q + TOTW'(ok_q);
				OP_SPLIT_BEGIN: begin
					gather_q <= 1'b1;
					hit_q    <= 1'b0;
					mv_cnt_q <= '0;
				end
				OP_SPLIT_MID: begin
					bc_q     <= bc_q + 1'b1;
					mv_idx_q <= '0;
				end
				OP_MV_NEXT: mv_idx_q <= mv_idx_q + 1'b1;
				OP_SPLIT_END: begin
					gather_q <= 1'b0;
					if (sp_next >= rb_q) begin
						sp_q <= '0;
						rb_q <= rb_q << 1;
					end else begin
						sp_q <= sp_next[BKW-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD_IN: begin
				rec_q <= in_rec;
				bk_q  <= bucket_of(in_rec, bc_q);
			end
			OP_PROD: prod_q <= PRODW'(cap_e) * PRODW'(bc_q);
			OP_SPLIT_BEGIN: bk_q <= sp_q;
			OP_MV_LATCH: begin
				rec_q <= m_rd;
				bk_q  <= bucket_of(m_rd, bc_q);
			end
			OP_BK_SP: bk_q <= sp_q;
			OP_EMIT: begin
				out_rec_q  <= rec_q;
				out_full_q <= !ok_q;
			end
			default: begin
			end
		endcase
	end

	assign st.clr_last   = clr_q == FAW'(FILL_DEPTH - 1);
	assign st.pg_end     = pg_q == npg_q;
	assign st.page_done  = !scan_more && !rdv_s1;
	assign st.hit        = hit_q;
	assign st.room       = room;
	assign st.ok         = ok_q;
	assign st.out_free   = !out_valid_q || out_ready;
	assign st.split_need = (bc_q < BCW'(MAX_BUCKETS)) && (quad_total >= three_prod);
	assign st.gather     = gather_q;
	assign st.tgt_sp     = bk_q == sp_q;
	assign st.mv_done    = mv_idx_q == mv_cnt_q;

	assign out_valid = out_valid_q;
	assign out_rec   = out_rec_q;
	assign out_full  = out_full_q;

endmodule

[hw/rtl/lhdf_ctrl.sv]
// Controller: sequences clear, lookup, insert, emit and bucket split.
`timescale 1ns / 1ps
module lhdf_ctrl import lhdf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t st,
	output dp_cmd_t    cmd
);

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_SC_PIB_RD,
		S_SC_PIB,
		S_SC_PAGE,
		S_SC_FILL,
		S_SC_REC,
		S_PL_PIB_RD,
		S_PL_PIB,
		S_PL_TEST,
		S_PL_FILL,
		S_PL_DONE,
		S_EMIT,
		S_CHK,
		S_SPLIT_CHK,
		S_SPLIT_MID,
		S_MV_CHECK,
		S_MV_LATCH,
		S_MV_TEST,
		S_MV_NEXT
	} state_t;

	// what the running place is for
	typedef enum logic [1:0] {
		CTX_INS,
		CTX_MVT,
		CTX_MVS
	} ctx_t;

	state_t state_q, state_d;
	ctx_t   ctx_q, ctx_d;

	always_comb begin
		state_d = state_q;
		ctx_d   = ctx_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (st.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD_IN;
					state_d = S_SC_PIB_RD;
				end
			end
			S_SC_PIB_RD: begin
				cmd.op  = OP_PIB_RD;
				state_d = S_SC_PIB;
			end
			S_SC_PIB: begin
				cmd.op  = OP_PIB_LATCH;
				state_d = S_SC_PAGE;
			end
			S_SC_PAGE: begin
				if (st.pg_end) begin
					if (st.gather) begin
						state_d = S_SPLIT_MID;
					end else begin
						ctx_d   = CTX_INS;
						state_d = S_PL_PIB_RD;
					end
				end else begin
					cmd.op  = OP_FILL_RD;
					state_d = S_SC_FILL;
				end
			end
			S_SC_FILL: begin
				cmd.op  = OP_FILL_LATCH;
				state_d = S_SC_REC;
			end
			S_SC_REC: begin
				if (st.hit) begin
					state_d = S_IDLE;
				end else if (st.page_done) begin
					cmd.op  = OP_PAGE_END;
					state_d = S_SC_PAGE;
				end else begin
					cmd.op = OP_REC_STEP;
				end
			end
			S_PL_PIB_RD: begin
				cmd.op  = OP_PIB_RD;
				state_d = S_PL_PIB;
			end
			S_PL_PIB: begin
				cmd.op  = OP_PIB_LATCH;
				state_d = S_PL_TEST;
			end
			S_PL_TEST: begin
				if (st.pg_end) begin
					cmd.op  = OP_PL_NEW;
					state_d = S_PL_DONE;
				end else begin
					cmd.op  = OP_FILL_RD;
					state_d = S_PL_FILL;
				end
			end
			S_PL_FILL: begin
				cmd.op  = OP_PL_FILL;
				state_d = st.room ? S_PL_DONE : S_PL_TEST;
			end
			S_PL_DONE: begin
				unique case (ctx_q)
					CTX_INS: state_d = S_EMIT;
					CTX_MVT: begin
						if (st.ok) begin
							state_d = S_MV_NEXT;
						end else begin
							cmd.op  = OP_BK_SP;
							ctx_d   = CTX_MVS;
							state_d = S_PL_PIB_RD;
						end
					end
					CTX_MVS: state_d = S_MV_NEXT;
					default: state_d = S_MV_NEXT;
				endcase
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.op  = OP_EMIT;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				cmd.op  = OP_PROD;
				state_d = S_SPLIT_CHK;
			end
			S_SPLIT_CHK: begin
				if (st.split_need) begin
					cmd.op  = OP_SPLIT_BEGIN;
					state_d = S_SC_PIB_RD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_SPLIT_MID: begin
				cmd.op  = OP_SPLIT_MID;
				state_d = S_MV_CHECK;
			end
			S_MV_CHECK: begin
				if (st.mv_done) begin
					cmd.op  = OP_SPLIT_END;
					state_d = S_IDLE;
				end else begin
					cmd.op  = OP_MV_RD;
					state_d = S_MV_LATCH;
				end
			end
			S_MV_LATCH: begin
				cmd.op  = OP_MV_LATCH;
				state_d = S_MV_TEST;
			end
			S_MV_TEST: begin
				ctx_d   = st.tgt_sp ? CTX_MVS : CTX_MVT;
				state_d = S_PL_PIB_RD;
			end
			S_MV_NEXT: begin
				cmd.op  = OP_MV_NEXT;
				state_d = S_MV_CHECK;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ctx_q   <= CTX_INS;
		end else begin
			state_q <= state_d;
			ctx_q   <= ctx_d;
		end
	end

	assign in_ready = state_q == S_IDLE;

endmodule

[hw/rtl/linear_hash_distinct_filter.sv]
// Top level of the linear-hash distinct-record filter.
`timescale 1ns / 1ps
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------
//  in       | in_valid / in_ready  | record (s32)
//  out      | out_valid / out_ready| new_record (s32), store_full
//  cfg      | cfg_valid / cfg_ready| page_capacity (7 bits)
//
// Reset starts a clearing pass of the page-fill and pages-per-bucket
// tables; in_ready and cfg_ready stay low until it ends, and cfg is taken only while idle.
// Lookup: page count, then per page its fill and its records, one store read per cycle;
// a miss then tests pages for room (opening a new page if none has it) to insert and emit.
// A split gathers the split bucket the same way, then places each moved record anew.
// One output register: a stalled out channel holds the result, the next request waits at emit.
module linear_hash_distinct_filter import lhdf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [REC_W-1:0] record,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [REC_W-1:0] new_record,
	output logic                    store_full,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CAP_W-1:0]        page_capacity
);

	dp_cmd_t          cmd;
	dp_status_t       st;
	logic [REC_W-1:0] out_rec;

	// capacity writes land only while idle, never under a request in flight
	assign cfg_ready = in_ready;

	lhdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	lhdf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_rec    (record),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (page_capacity),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_rec   (out_rec),
		.out_full  (store_full)
	);

	assign new_record = out_rec;

	// a taken request keeps the block busy in the cycle after it
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	// a result is only loaded when the output register can take it
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_EMIT |-> st.out_free)
		else $error("result overwrote a pending output");

	// a record found in its bucket never produces a result
	a_no_emit_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_EMIT |-> !st.hit)
		else $error("duplicate record emitted");

endmodule
